// File: src/was_pkg.sv
// Package with shared constants and controller/datapath interface types for the angle sampler.
package was_pkg;

  localparam int MAX_ENERGY_BINS_DEF = 16;
  localparam int MAX_ANGLE_BINS_DEF  = 256;
  localparam int WEIGHT_BITS_DEF     = 16;

  localparam int ENERGY_W = 4;
  localparam int ANGLE_W  = 8;
  localparam int WIN_W    = 16;
  localparam int FRAC_W   = 24;
  localparam int BIT_W    = 5;
  localparam int CFG_W    = 9;

  localparam logic [CFG_W-1:0] ANGLES_IN_USE_RST = CFG_W'(180);

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic load;
    logic capture;
    logic sum_en;
    logic mul_en;
    logic search_init;
    logic search_en;
    logic res_out;
  } was_cmd_t;

  typedef struct packed {
    logic row_ok;
    logic sum_last;
    logic mul_last;
    logic total_zero;
    logic found;
    logic exhausted;
    logic out_free;
  } was_sts_t;

endpackage

// File: src/weighted_angle_sampler.sv
// Top level of the weighted angle sampler: controller, datapath and ports.
// A load transaction writes one weight. In a sample transaction the single read port
// of the weight memory walks the first n bins of the row once to form their total and
// again up to the chosen bin, where n is angles_in_use clamped to MAX_ANGLE_BINS, and a
// bit-serial multiply between the two walks scales the fraction by the total.
// One sample is in work at a time; its result sits in an output register, so the next
// transaction is accepted while that result waits. Weights read before being loaded are
// undefined, and angles_in_use may only be written while the block is idle.
module weighted_angle_sampler #(
  parameter int MAX_ENERGY_BINS = was_pkg::MAX_ENERGY_BINS_DEF,
  parameter int MAX_ANGLE_BINS  = was_pkg::MAX_ANGLE_BINS_DEF,
  parameter int WEIGHT_BITS     = was_pkg::WEIGHT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [was_pkg::ENERGY_W-1:0] in_energy_bin,
  input  logic [was_pkg::ANGLE_W-1:0]  in_angle_bin,
  input  logic [was_pkg::WIN_W-1:0]    in_weight,
  input  logic [was_pkg::FRAC_W-1:0]   in_random_fraction,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [was_pkg::ANGLE_W-1:0]  out_chosen_angle_bin,
  output logic                         out_valid_res,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [was_pkg::CFG_W-1:0]    cfg_angles_in_use
);

  was_pkg::was_cmd_t cmd;
  was_pkg::was_sts_t sts;

  was_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .sts        (sts),
    .in_stall   (in_stall),
    .cmd        (cmd)
  );

  was_dp #(
    .MAX_ENERGY_BINS (MAX_ENERGY_BINS),
    .MAX_ANGLE_BINS  (MAX_ANGLE_BINS),
    .WEIGHT_BITS     (WEIGHT_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_energy_bin        (in_energy_bin),
    .in_angle_bin         (in_angle_bin),
    .in_weight            (in_weight),
    .in_random_fraction   (in_random_fraction),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_angles_in_use    (cfg_angles_in_use),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_chosen_angle_bin (out_chosen_angle_bin),
    .out_valid_res        (out_valid_res)
  );

endmodule

// File: src/was_ctrl.sv
// Controller state machine that sequences loads and the sum, scale and search phases of a sample.
module was_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_command,
  input  was_pkg::was_sts_t sts,
  output logic              in_stall,
  output was_pkg::was_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SUM    = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_SEARCH = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_command == was_pkg::CMD_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = sts.row_ok ? ST_SUM : ST_FIN;
          end
        end
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        if (sts.sum_last) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (sts.mul_last) begin
          cmd.search_init = 1'b1;
          state_nxt       = sts.total_zero ? ST_FIN : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search_en = 1'b1;
        if (sts.found || sts.exhausted) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.res_out = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/was_dp.sv
// Datapath with the weight memory, row sum, serial fraction scaling, search and result register.
module was_dp #(
  parameter int MAX_ENERGY_BINS = was_pkg::MAX_ENERGY_BINS_DEF,
  parameter int MAX_ANGLE_BINS  = was_pkg::MAX_ANGLE_BINS_DEF,
  parameter int WEIGHT_BITS     = was_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  was_pkg::was_cmd_t             cmd,
  output was_pkg::was_sts_t             sts,
  input  logic [was_pkg::ENERGY_W-1:0]  in_energy_bin,
  input  logic [was_pkg::ANGLE_W-1:0]   in_angle_bin,
  input  logic [was_pkg::WIN_W-1:0]     in_weight,
  input  logic [was_pkg::FRAC_W-1:0]    in_random_fraction,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [was_pkg::CFG_W-1:0]     cfg_angles_in_use,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [was_pkg::ANGLE_W-1:0]   out_chosen_angle_bin,
  output logic                          out_valid_res
);

  localparam int DEPTH  = MAX_ENERGY_BINS * MAX_ANGLE_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_ANGLE_BINS);
  localparam int CNT_W  = $clog2(MAX_ANGLE_BINS + 1);
  localparam int TOT_W  = WEIGHT_BITS + IDX_W;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];

  logic [was_pkg::CFG_W-1:0]    ang_use_r, ang_use_nxt;
  logic [was_pkg::ENERGY_W-1:0] row_r, row_nxt;
  logic [was_pkg::FRAC_W-1:0]   frac_r, frac_nxt;
  logic [CNT_W-1:0]             n_r, n_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]             rd_idx_r, rd_idx_nxt;
  logic [WEIGHT_BITS-1:0]       rd_data_r;
  logic [TOT_W-1:0]             total_r, total_nxt;
  logic [TOT_W-1:0]             acc_r, acc_nxt;
  logic [was_pkg::BIT_W-1:0]    bit_r, bit_nxt;
  logic [TOT_W-1:0]             run_r, run_nxt;
  logic [was_pkg::ANGLE_W-1:0]  res_ang_r, res_ang_nxt;
  logic                         res_ok_r, res_ok_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [was_pkg::ANGLE_W-1:0]  out_ang_r, out_ang_nxt;
  logic                         out_ok_r, out_ok_nxt;

  logic                   row_ok, col_ok, we, issue;
  logic [ADDR_W-1:0]      waddr, raddr;
  logic [31:0]            w_ext;
  logic [WEIGHT_BITS-1:0] wdata;
  logic [TOT_W-1:0]       rd_ext, run_sum;
  logic [TOT_W:0]         mul_sum;
  logic [31:0]            n_clamp;
  logic                   found;

  assign row_ok  = 32'(in_energy_bin) < 32'(MAX_ENERGY_BINS);
  assign col_ok  = 32'(in_angle_bin) < 32'(MAX_ANGLE_BINS);
  assign we      = cmd.load && row_ok && col_ok;
  assign waddr   = ADDR_W'(32'(in_energy_bin) * 32'(MAX_ANGLE_BINS) + 32'(in_angle_bin));
  assign raddr   = ADDR_W'(32'(row_r) * 32'(MAX_ANGLE_BINS) + 32'(cnt_r));
  assign w_ext   = 32'(in_weight);
  assign wdata   = w_ext[WEIGHT_BITS-1:0];
  assign issue   = (cmd.sum_en || cmd.search_en) && (cnt_r < n_r);
  assign rd_ext  = TOT_W'(rd_data_r);
  assign run_sum = run_r + rd_ext;
  assign mul_sum = {1'b0, acc_r} + {1'b0, (frac_r[0] ? total_r : {TOT_W{1'b0}})};
  assign n_clamp = (32'(ang_use_r) > 32'(MAX_ANGLE_BINS)) ? 32'(MAX_ANGLE_BINS)
                                                          : 32'(ang_use_r);
  assign found   = cmd.search_en && rd_vld_r && (run_sum > acc_r);

  assign sts.row_ok     = row_ok;
  assign sts.sum_last   = cnt_r == n_r;
  assign sts.mul_last   = bit_r == was_pkg::BIT_W'(was_pkg::FRAC_W - 1);
  assign sts.total_zero = total_r == '0;
  assign sts.found      = found;
  assign sts.exhausted  = (cnt_r == n_r) && !rd_vld_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_chosen_angle_bin = out_ang_r;
  assign out_valid_res        = out_ok_r;

  always_comb begin
    ang_use_nxt   = ang_use_r;
    row_nxt       = row_r;
    frac_nxt      = frac_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = issue;
    rd_idx_nxt    = rd_idx_r;
    total_nxt     = total_r;
    acc_nxt       = acc_r;
    bit_nxt       = bit_r;
    run_nxt       = run_r;
    res_ang_nxt   = res_ang_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r;
    out_ang_nxt   = out_ang_r;
    out_ok_nxt    = out_ok_r;

    if (cfg_valid) begin
      ang_use_nxt = cfg_angles_in_use;
    end
    if (issue) begin
      cnt_nxt    = cnt_r + CNT_W'(1);
      rd_idx_nxt = cnt_r[IDX_W-1:0];
    end
    if (cmd.capture) begin
      row_nxt     = in_energy_bin;
      frac_nxt    = in_random_fraction;
      n_nxt       = CNT_W'(n_clamp);
      cnt_nxt     = '0;
      rd_vld_nxt  = 1'b0;
      total_nxt   = '0;
      acc_nxt     = '0;
      bit_nxt     = '0;
      res_ang_nxt = '0;
      res_ok_nxt  = 1'b0;
    end
    if (cmd.sum_en && rd_vld_r) begin
      total_nxt = total_r + rd_ext;
    end
    if (cmd.mul_en) begin
      acc_nxt  = mul_sum[TOT_W:1];
      frac_nxt = frac_r >> 1;
      bit_nxt  = bit_r + was_pkg::BIT_W'(1);
    end
    if (cmd.search_init) begin
      cnt_nxt    = '0;
      rd_vld_nxt = 1'b0;
      run_nxt    = '0;
    end
    if (cmd.search_en && rd_vld_r) begin
      run_nxt = run_sum;
    end
    if (found) begin
      res_ang_nxt = was_pkg::ANGLE_W'(32'(rd_idx_r));
      res_ok_nxt  = 1'b1;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.res_out) begin
      out_valid_nxt = 1'b1;
      out_ang_nxt   = res_ang_r;
      out_ok_nxt    = res_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_use_r   <= was_pkg::ANGLES_IN_USE_RST;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ang_use_r   <= ang_use_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    frac_r    <= frac_nxt;
    n_r       <= n_nxt;
    cnt_r     <= cnt_nxt;
    rd_idx_r  <= rd_idx_nxt;
    total_r   <= total_nxt;
    acc_r     <= acc_nxt;
    bit_r     <= bit_nxt;
    run_r     <= run_nxt;
    res_ang_r <= res_ang_nxt;
    res_ok_r  <= res_ok_nxt;
    out_ang_r <= out_ang_nxt;
    out_ok_r  <= out_ok_nxt;
  end

  // The scaled target stays below the row total throughout the serial multiply.
  a_target_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_en && (total_r != '0)) |=> (acc_r < total_r))
    else $error("scaled target not below row total");

  // Returned read data always belongs to a bin inside the covered range.
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (32'(rd_idx_r) < 32'(n_r)))
    else $error("read index beyond covered bins");

  // A result transaction is only offered after the controller releases one.
  a_out_from_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.res_out))
    else $error("result offered without controller release");

endmodule
